FILE: sv/swef_pkg.sv
package swef_pkg;

    localparam int MAX_WIDTH_DEF = 255;
    localparam int SAMPLE_W      = 32;
    localparam int WINDOW_W      = 8;
    localparam int CFG_IDX_W     = 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [WINDOW_W-1:0]        window_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    localparam cfg_idx_t CFG_WINDOW_WIDTH = 1'd0;
    localparam cfg_idx_t CFG_UPPER_MODE   = 1'd1;

endpackage

FILE: sv/sliding_window_extreme_filter.sv
// Running maximum / minimum over a trailing window of trace samples.
// Input channel s_*: one sample per beat, s_start_of_trace marks the first
// sample of a trace and empties the history before that sample is used.
// Result channel m_*: one extreme value per input beat, in order.
// Configuration: cfg_wr_en / cfg_index / cfg_wr_data, index 0 is the window
// width (preceding samples besides the current one), index 1 selects
// maximum (1) or minimum (0). Write only while the block is idle.
// Each beat reads its n preceding samples, one per cycle, from a history
// memory with separate read and write ports, with n = min(window width,
// samples seen in this trace). A beat occupies the block until its scan
// is done and its result has entered the result register; the read port
// of the history memory paces the scan. No new beat is taken before then.
// The result sits in an output register, so a stalled receiver only holds
// the block once a second finished result has nowhere to go.
// Reset clears the sample count, write position and handshakes; window
// width goes to 0 and maximum mode is selected. History contents need no
// clearing: only samples of the current trace are ever read.
module sliding_window_extreme_filter #(
    parameter int MAX_WIDTH = swef_pkg::MAX_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  swef_pkg::cfg_idx_t   cfg_index,
    input  swef_pkg::window_t    cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  swef_pkg::sample_t    s_sample,
    input  logic                 s_start_of_trace,
    output logic                 m_valid,
    input  logic                 m_ready,
    output swef_pkg::sample_t    m_extreme_value
);
    import swef_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (SW > WINDOW_W) ? SW : WINDOW_W;
    localparam int CW = (SW < WINDOW_W) ? SW : WINDOW_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);
    localparam logic [SW-1:0] SEEN_MAX  = SW'(MAX_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_ADDR : a - AW'(1);
    endfunction

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    state_t          state_reg, state_next;
    window_t         width_reg;
    logic            upper_reg;
    logic [SW-1:0]   seen_reg, seen_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic [AW-1:0]   rd_addr_reg, rd_addr_next;
    logic [CW-1:0]   remain_reg, remain_next;
    logic            rd_pend_reg, rd_pend_next;
    sample_t         cur_reg, cur_next;
    sample_t         best_reg, best_next;
    logic            m_valid_reg, m_valid_next;
    sample_t         m_data_reg, m_data_next;

    logic            in_beat;
    logic            out_free;
    logic [SW-1:0]   seen_start;
    logic [EW-1:0]   width_ext, seen_ext;
    logic [CW-1:0]   n_look;
    logic            mem_wr_en;
    logic            mem_rd_en;
    logic [AW-1:0]   mem_rd_addr;
    sample_t         mem_rd_data;
    logic            take_rd;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign seen_start = s_start_of_trace ? '0 : seen_reg;
    assign width_ext  = EW'(width_reg);
    assign seen_ext   = EW'(seen_start);
    assign n_look     = (width_ext < seen_ext) ? CW'(width_ext) : CW'(seen_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= '0;
            upper_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WINDOW_WIDTH: width_reg <= cfg_wr_data;
                CFG_UPPER_MODE:   upper_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // compare the word read last cycle against the running best
    always_comb begin
        take_rd = upper_reg ? (mem_rd_data > best_reg) : (mem_rd_data < best_reg);
    end

    always_comb begin
        state_next   = state_reg;
        seen_next    = seen_reg;
        wp_next      = wp_reg;
        rd_addr_next = rd_addr_reg;
        remain_next  = remain_reg;
        rd_pend_next = 1'b0;
        cur_next     = cur_reg;
        best_next    = best_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_wr_en    = 1'b0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = rd_addr_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    cur_next  = s_sample;
                    best_next = s_sample;
                    seen_next = seen_start;
                    if (n_look == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        mem_rd_en    = 1'b1;
                        mem_rd_addr  = addr_dec(wp_reg);
                        rd_addr_next = addr_dec(addr_dec(wp_reg));
                        remain_next  = n_look - CW'(1);
                        rd_pend_next = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_pend_reg && take_rd) begin
                    best_next = mem_rd_data;
                end
                if (remain_reg != '0) begin
                    mem_rd_en    = 1'b1;
                    rd_addr_next = addr_dec(rd_addr_reg);
                    remain_next  = remain_reg - CW'(1);
                    rd_pend_next = 1'b1;
                end else if (rd_pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register can take the value
                if (out_free) begin
                    mem_wr_en    = 1'b1;
                    wp_next      = addr_inc(wp_reg);
                    seen_next    = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + SW'(1);
                    m_data_next  = best_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seen_reg    <= '0;
            wp_reg      <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seen_reg    <= seen_next;
            wp_reg      <= wp_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        remain_reg  <= remain_next;
        cur_reg     <= cur_next;
        best_reg    <= best_next;
        m_data_reg  <= m_data_next;
    end

    swef_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (wp_reg),
        .wr_data (cur_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign m_valid         = m_valid_reg;
    assign m_extreme_value = m_data_reg;

endmodule

FILE: sv/swef_store.sv
module swef_store #(
    parameter int DEPTH = swef_pkg::MAX_WIDTH_DEF,
    parameter int AW    = 8
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  swef_pkg::sample_t    wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output swef_pkg::sample_t    rd_data
);
    import swef_pkg::*;

    sample_t mem [DEPTH];
    sample_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/tb_sliding_window_extreme_filter.sv
`timescale 1ns / 100ps

module tb_sliding_window_extreme_filter;

    import swef_pkg::*;

    localparam int          HISTORY_DEPTH    = MAX_WIDTH_DEF;
    localparam int unsigned RANDOM_ITEMS     = 1150;
    localparam int unsigned END_QUIET_CYCLES = 300;
    localparam int unsigned MAX_REPORTS      = 10;

    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    typedef enum logic [1:0] {
        STYLE_FULL,
        STYLE_NARROW,
        STYLE_EXTREME,
        STYLE_RAMP
    } sample_style_t;

    logic     aclk;
    logic     aresetn;
    logic     cfg_wr_en;
    cfg_idx_t cfg_index;
    window_t  cfg_wr_data;
    logic     s_valid;
    logic     s_ready;
    sample_t  s_sample;
    logic     s_start_of_trace;
    logic     m_valid;
    logic     m_ready;
    sample_t  m_extreme_value;

    // Predictor state
    sample_t     history_samples [HISTORY_DEPTH];
    int unsigned history_count;
    int unsigned history_wr_ptr;
    int unsigned window_setting;
    logic        max_mode;

    sample_t     expected_extremes [$];
    int unsigned error_count;

    int unsigned send_idle_max;
    int unsigned recv_idle_max;
    int unsigned hold_off_cycles;

    sliding_window_extreme_filter u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_start_of_trace (s_start_of_trace),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_extreme_value  (m_extreme_value)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #30ms;
        $display("tb_sliding_window_extreme_filter: FAIL");
        $finish;
    end

    function automatic sample_t predict_extreme(sample_t value, logic start);
        sample_t     best;
        int unsigned span;
        int unsigned idx;
        best = value;
        if (start) begin
            history_count = 0;
        end
        span = (window_setting < history_count) ? window_setting : history_count;
        if (span > HISTORY_DEPTH) begin
            span = HISTORY_DEPTH;
        end
        for (int unsigned k = 1; k <= span; k++) begin
            idx = (history_wr_ptr + HISTORY_DEPTH - k) % HISTORY_DEPTH;
            if (max_mode ? (history_samples[idx] > best) : (history_samples[idx] < best)) begin
                best = history_samples[idx];
            end
        end
        history_samples[history_wr_ptr] = value;
        history_wr_ptr = (history_wr_ptr + 1) % HISTORY_DEPTH;
        if (history_count < HISTORY_DEPTH) begin
            history_count++;
        end
        return best;
    endfunction

    function automatic sample_t draw_sample(sample_style_t style, int unsigned pos,
                                            sample_t base, sample_t step);
        case (style)
            STYLE_NARROW: begin
                return sample_t'($urandom_range(0, 6)) - 3;
            end
            STYLE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return SAMPLE_MIN;
                    1:       return SAMPLE_MAX;
                    2:       return '0;
                    3:       return '1;
                    default: return sample_t'(1);
                endcase
            end
            STYLE_RAMP: begin
                return base + step * sample_t'(pos);
            end
            default: begin
                return sample_t'($urandom());
            end
        endcase
    endfunction

    task automatic write_register(cfg_idx_t index, window_t data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        case (index)
            CFG_WINDOW_WIDTH: window_setting = 32'(data);
            CFG_UPPER_MODE:   max_mode       = data[0];
            default:          ;
        endcase
    endtask

    task automatic send_sample(sample_t value, logic start);
        int unsigned gap;
        gap = $urandom_range(0, send_idle_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_sample         <= value;
        s_start_of_trace <= start;
        do @(posedge aclk); while (s_ready !== 1'b1);
        expected_extremes.push_back(predict_extreme(value, start));
        @(negedge aclk);
    endtask

    // Drop valid and hold until every outstanding result has been taken
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_extremes.size() != 0);
    endtask

    task automatic configure_window(window_t width, logic upper);
        drain_results();
        write_register(CFG_WINDOW_WIDTH, width);
        // upper bits of the mode register are junk and must be dropped
        write_register(CFG_UPPER_MODE, {7'($urandom_range(0, 127)), upper});
    endtask

    task automatic send_trace(int unsigned len, logic flagged, sample_style_t style);
        sample_t base;
        sample_t step;
        logic    start;
        base = sample_t'($urandom());
        step = sample_t'($urandom_range(1, 2000));
        if ($urandom_range(0, 1) == 1) begin
            step = -step;
        end
        for (int unsigned i = 0; i < len; i++) begin
            start = (i == 0) ? flagged : ($urandom_range(0, 49) == 0);
            send_sample(draw_sample(style, i, base, step), start);
        end
    endtask

    task automatic test_reset_defaults();
        // width 0 and maximum mode out of reset: each result is its own sample
        send_sample(32'sd123, 1'b0);
        send_sample(-32'sd5, 1'b0);
        send_sample(32'sd77, 1'b0);
    endtask

    task automatic test_field_extremes();
        configure_window(8'd2, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        drain_results();
        write_register(CFG_UPPER_MODE, 8'hFE);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample('0, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample('1, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
    endtask

    task automatic test_mid_trace_config();
        configure_window(8'd1, 1'b1);
        send_sample(32'sd10, 1'b1);
        send_sample(32'sd40, 1'b0);
        send_sample(32'sd20, 1'b0);
        send_sample(32'sd30, 1'b0);
        // new width and mode apply to the history already stored
        configure_window(8'd3, 1'b0);
        send_sample(32'sd50, 1'b0);
        send_sample(32'sd60, 1'b0);
    endtask

    task automatic test_wide_window();
        // falling ramp in maximum mode: each result is the oldest sample in the window
        configure_window(8'd255, 1'b1);
        for (int i = 0; i < 300; i++) begin
            send_sample(sample_t'(-7 * i), i == 0);
        end
        configure_window(8'd255, 1'b0);
        for (int i = 0; i < 260; i++) begin
            send_sample(sample_t'(3 * i) - 32'sd1000, i == 0);
        end
    endtask

    task automatic test_flow_control();
        configure_window(8'd4, 1'b1);
        send_idle_max   = 0;
        recv_idle_max   = 0;
        hold_off_cycles = 400;
        send_trace(30, 1'b1, STYLE_FULL);
        // pause mid-trace until every result is back, then carry on
        drain_results();
        send_trace(20, 1'b0, STYLE_NARROW);
        send_idle_max = 5;
        recv_idle_max = 5;
    endtask

    task automatic test_random_traces();
        int unsigned sent;
        int unsigned len;
        window_t     width;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                width = window_t'($urandom_range(0, 255));
            end else begin
                width = window_t'($urandom_range(0, 12));
            end
            configure_window(width, $urandom_range(0, 1) == 1);
            send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            repeat ($urandom_range(2, 6)) begin
                len = $urandom_range(1, 60);
                send_trace(len, $urandom_range(0, 19) != 0,
                           sample_style_t'($urandom_range(0, 3)));
                sent += len;
            end
        end
        send_idle_max = 5;
        recv_idle_max = 5;
    endtask

    initial begin : result_sink
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, recv_idle_max);
            if (hold_off_cycles > 0) begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        sample_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_extremes.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%0t: result beat %0d with nothing expected",
                             $time, m_extreme_value);
                end
            end else begin
                want = expected_extremes.pop_front();
                if (m_extreme_value !== want) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: extreme_value expected %0d (0x%h), got %0d (0x%h)",
                                 $time, want, want, m_extreme_value, m_extreme_value);
                    end
                end
            end
        end
    end

    initial begin
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = CFG_WINDOW_WIDTH;
        cfg_wr_data      = '0;
        s_valid          = 1'b0;
        s_sample         = '0;
        s_start_of_trace = 1'b0;
        error_count      = 0;
        send_idle_max    = 5;
        recv_idle_max    = 5;
        hold_off_cycles  = 0;
        history_count    = 0;
        history_wr_ptr   = 0;
        window_setting   = 0;
        max_mode         = 1'b1;
        foreach (history_samples[i]) history_samples[i] = '0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_field_extremes();
        test_mid_trace_config();
        test_wide_window();
        test_flow_control();
        test_random_traces();

        drain_results();
        repeat (END_QUIET_CYCLES) @(negedge aclk);
        if (error_count == 0 && expected_extremes.size() == 0) begin
            $display("tb_sliding_window_extreme_filter: PASS");
        end else begin
            $display("tb_sliding_window_extreme_filter: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/swef_pkg.sv
sv/swef_store.sv
sv/sliding_window_extreme_filter.sv
tb/tb_sliding_window_extreme_filter.sv
